@@ rtl/qpr_pkg.sv @@
package qpr_pkg;

    localparam int CompW  = 32;
    localparam int FracW  = 16;
    localparam int ProdW  = 2 * CompW;
    localparam int SumW   = ProdW + 2;
    localparam int ShW    = SumW - FracW;

    typedef logic signed [CompW-1:0] t_comp;
    typedef logic signed [ProdW-1:0] t_prod;
    typedef logic signed [SumW-1:0]  t_sum;
    typedef t_comp                   t_quat [4];

    typedef enum logic {
        FUNC_MUL = 1'b0,
        FUNC_ROT = 1'b1
    } t_func;

    // Side data carried alongside a product through the multiply stages.
    typedef struct {
        t_func func;
        logic  sat;
        t_quat a;
        t_quat t;
    } t_side;

    localparam t_comp COMP_MAX = {1'b0, {(CompW-1){1'b1}}};
    localparam t_comp COMP_MIN = {1'b1, {(CompW-1){1'b0}}};

    // Term n of component c is x[n] * y[c ^ n]; bit n set negates the term.
    localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

endpackage

@@ rtl/qpr_if.sv @@
interface qpr_in_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic signed [31:0]        a_w;
    logic signed [31:0]        a_i;
    logic signed [31:0]        a_j;
    logic signed [31:0]        a_k;
    logic signed [31:0]        b_w;
    logic signed [31:0]        b_i;
    logic signed [31:0]        b_j;
    logic signed [31:0]        b_k;

    modport source (output valid, func, a_w, a_i, a_j, a_k, b_w, b_i, b_j, b_k,
                    input ready);
    modport sink   (input valid, func, a_w, a_i, a_j, a_k, b_w, b_i, b_j, b_k,
                    output ready);
endinterface

interface qpr_out_if;
    logic                      valid;
    logic                      ready;
    logic signed [31:0]        r_w;
    logic signed [31:0]        r_i;
    logic signed [31:0]        r_j;
    logic signed [31:0]        r_k;
    logic                      saturated;

    modport source (output valid, r_w, r_i, r_j, r_k, saturated, input ready);
    modport sink   (input valid, r_w, r_i, r_j, r_k, saturated, output ready);
endinterface

@@ rtl/quaternion_product_and_rotation.sv @@
// Quaternion Hamilton product and rotation, signed Q16.16.
//
// Channels: i_req carries a transaction with func, quaternion a and operand b;
// o_rsp returns one transaction per request with r_w..r_k and a saturated flag.
// func FUNC_MUL returns a*b, FUNC_ROT returns a*b*conj(a) (a assumed unit).
// Each component is the exact four-product sum, floor-shifted right by 16 and
// clipped to 32 bits; the a*b intermediate of a rotation is clipped too.
//
// Pipeline: two stages for a*b, two for the conjugate product, and one
// output register. Throughput: one transaction per cycle unless o_rsp stalls;
// every stage is a 32x32 multiply rank or a 66-bit four-term add with clip,
// so nothing loops back.
//
// Reset clears all valid bits; results in flight are dropped.
// When the receiver stalls, each stage holds only while its successor is
// full, so empty stages keep filling and i_req.ready falls only once the
// whole pipeline is occupied. No transaction is lost or repeated.
module quaternion_product_and_rotation (
    input  logic            i_clk,
    input  logic            i_rst_n,
    qpr_in_if.sink          i_req,
    qpr_out_if.source       o_rsp
);
    import qpr_pkg::*;

    // Front multiplier: t = a * b
    t_quat in_a, in_b;
    t_side side_in;
    logic  v1, rdy1;
    t_quat q1;
    logic  sat1;
    t_side side1;

    // Back multiplier: t * conj(a)
    t_side side_mid;
    logic  v2, rdy2;
    t_quat q2;
    logic  sat2;
    t_side side2;

    // Output register
    logic  r_ov;
    t_quat r_res, n_res;
    logic  r_rsat, n_rsat;
    logic  en_o;

    assign in_a = '{i_req.a_w, i_req.a_i, i_req.a_j, i_req.a_k};
    assign in_b = '{i_req.b_w, i_req.b_i, i_req.b_j, i_req.b_k};

    always_comb begin
        side_in.func = t_func'(i_req.func);
        side_in.sat  = 1'b0;
        side_in.a    = in_a;
        side_in.t    = '{default: '0};
    end

    qpr_qmul u_mul_ab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_conj  (1'b0),
        .i_v     (i_req.valid),
        .o_rdy   (rdy1),
        .i_x     (in_a),
        .i_y     (in_b),
        .i_side  (side_in),
        .o_v     (v1),
        .i_rdy   (rdy2),
        .o_q     (q1),
        .o_sat   (sat1),
        .o_side  (side1)
    );

    assign i_req.ready = rdy1;

    // Keep the clipped a*b and its flag for the plain product case
    always_comb begin
        side_mid.func = side1.func;
        side_mid.sat  = sat1;
        side_mid.a    = side1.a;
        side_mid.t    = q1;
    end

    qpr_qmul u_mul_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_conj  (1'b1),
        .i_v     (v1),
        .o_rdy   (rdy2),
        .i_x     (q1),
        .i_y     (side1.a),
        .i_side  (side_mid),
        .o_v     (v2),
        .i_rdy   (en_o),
        .o_q     (q2),
        .o_sat   (sat2),
        .o_side  (side2)
    );

    // Select the result by operation; advance when the output slot frees up
    assign en_o = !r_ov || o_rsp.ready;

    always_comb begin
        unique case (side2.func)
            FUNC_ROT: begin
                n_res  = q2;
                n_rsat = sat2;
            end
            FUNC_MUL: begin
                n_res  = side2.t;
                n_rsat = side2.sat;
            end
            default: begin
                n_res  = side2.t;
                n_rsat = side2.sat;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_o) begin
            r_ov <= v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_res  <= n_res;
            r_rsat <= n_rsat;
        end
    end

    assign o_rsp.valid     = r_ov;
    assign o_rsp.r_w       = r_res[0];
    assign o_rsp.r_i       = r_res[1];
    assign o_rsp.r_j       = r_res[2];
    assign o_rsp.r_k       = r_res[3];
    assign o_rsp.saturated = r_rsat;

endmodule

@@ rtl/qpr_qmul.sv @@
module qpr_qmul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_conj,
    input  logic           i_v,
    output logic           o_rdy,
    input  qpr_pkg::t_quat i_x,
    input  qpr_pkg::t_quat i_y,
    input  qpr_pkg::t_side i_side,
    output logic           o_v,
    input  logic           i_rdy,
    output qpr_pkg::t_quat o_q,
    output logic           o_sat,
    output qpr_pkg::t_side o_side
);
    import qpr_pkg::*;

    logic  r_va, r_vb;
    logic  en_a, en_b;
    t_prod r_p [4][4];
    t_prod n_p [4][4];
    t_side r_sa, r_sb;
    t_quat r_q, n_q;
    logic  r_sat, n_sat;

    assign en_b  = !r_vb || i_rdy;
    assign en_a  = !r_va || en_b;
    assign o_rdy = en_a;

    // Stage A: sixteen signed products, sign folded in
    always_comb begin
        logic [1:0] idx;
        logic       neg;
        t_prod      prod;
        for (int c = 0; c < 4; c++) begin
            for (int n = 0; n < 4; n++) begin
                idx  = 2'(c) ^ 2'(n);
                neg  = HAM_NEG[c][n] ^ (i_conj && (idx != 2'd0));
                prod = i_x[n] * i_y[idx];
                n_p[c][n] = neg ? -prod : prod;
            end
        end
    end

    // Stage B: exact four-term sum, floor shift, clip to 32 bits
    always_comb begin
        t_sum            acc;
        logic [ShW-1:0]  sh;
        n_sat = r_sa.sat;
        for (int c = 0; c < 4; c++) begin
            acc = t_sum'(r_p[c][0]) + t_sum'(r_p[c][1])
                + t_sum'(r_p[c][2]) + t_sum'(r_p[c][3]);
            sh  = acc[SumW-1:FracW];
            if (sh[ShW-1:CompW-1] == '0 || sh[ShW-1:CompW-1] == '1) begin
                n_q[c] = sh[CompW-1:0];
            end else begin
                n_q[c] = sh[ShW-1] ? COMP_MIN : COMP_MAX;
                n_sat  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_v;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_p  <= n_p;
            r_sa <= i_side;
        end
        if (en_b) begin
            r_q   <= n_q;
            r_sat <= n_sat;
            r_sb  <= r_sa;
        end
    end

    assign o_v    = r_vb;
    assign o_q    = r_q;
    assign o_sat  = r_sat;
    assign o_side = r_sb;

`ifndef SYNTHESIS
    a_hold_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vb && !i_rdy) |=> (r_vb && $stable(r_q[0]) && $stable(r_sat)))
        else $error("stalled result stage changed");

    a_hold_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_va && !en_b) |=> (r_va && $stable(r_p[0][0]) && $stable(r_p[3][3])))
        else $error("stalled product stage changed");

    a_sat_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vb && r_sb.sat) |-> r_sat)
        else $error("earlier saturation dropped");
`endif

endmodule

@@ verif/testbench.sv @@
module testbench;

    import qpr_pkg::*;

    // Percent of cycles in which each side holds off, and the run-end guards.
    localparam int IDLE_PCT      = 27;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_OPS    = 1030;
    // Window of accepted requests during which neither side idles.
    localparam int CALM_FIRST    = 400;
    localparam int CALM_LAST     = 650;

    localparam t_comp Q_ONE      = 32'sh0001_0000;
    localparam t_comp Q_COS45    = 32'sd46341;

    // 33 bits hold a negated component exactly; 66 bits hold a four-product sum.
    typedef logic signed [32:0] t_wide;
    typedef logic signed [65:0] t_acc;

    typedef struct packed {
        t_func func;
        t_comp a_w, a_i, a_j, a_k;
        t_comp b_w, b_i, b_j, b_k;
    } t_qop;

    typedef struct packed {
        t_comp r_w, r_i, r_j, r_k;
        logic  sat;
    } t_qres;

    logic i_clk;
    logic i_rst_n;

    qpr_in_if  req_if ();
    qpr_out_if rsp_if ();

    quaternion_product_and_rotation i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_qop  ops_to_send [$];
    t_qres results_due [$];
    t_qop  op_on_bus;
    bit    op_taken;
    int    total_ops;
    int    ops_sent;
    int    results_seen;
    int    mul_cnt;
    int    rot_cnt;
    int    sat_cnt;
    int    err_cnt;
    int    quiet_cycles;

    // ------------------------------------------------------------------
    // Prediction: exact Hamilton product with floor shift and clipping.
    // ------------------------------------------------------------------

    function automatic t_acc full_term(input t_wide p, input t_wide q);
        t_acc pe;
        t_acc qe;
        pe = p;
        qe = q;
        return pe * qe;
    endfunction

    // Shift the exact sum right by the fraction width (floor), then clip.
    function automatic t_comp clip_shift(input t_acc s, inout logic sat);
        t_acc sh;
        sh = s >>> FracW;
        if (sh > 66'sd2147483647) begin
            sat = 1'b1;
            return COMP_MAX;
        end
        if (sh < -66'sd2147483648) begin
            sat = 1'b1;
            return COMP_MIN;
        end
        return t_comp'(sh[CompW-1:0]);
    endfunction

    // r = x * y with i*j = k.
    function automatic void ham_product(input t_wide x [4], input t_wide y [4],
                                        output t_comp r [4], inout logic sat);
        r[0] = clip_shift(full_term(x[0], y[0]) - full_term(x[1], y[1])
                        - full_term(x[2], y[2]) - full_term(x[3], y[3]), sat);
        r[1] = clip_shift(full_term(x[0], y[1]) + full_term(x[1], y[0])
                        + full_term(x[2], y[3]) - full_term(x[3], y[2]), sat);
        r[2] = clip_shift(full_term(x[0], y[2]) - full_term(x[1], y[3])
                        + full_term(x[2], y[0]) + full_term(x[3], y[1]), sat);
        r[3] = clip_shift(full_term(x[0], y[3]) + full_term(x[1], y[2])
                        - full_term(x[2], y[1]) + full_term(x[3], y[0]), sat);
    endfunction

    function automatic t_qres quat_result(input t_qop op);
        t_wide a [4];
        t_wide b [4];
        t_wide t [4];
        t_wide c [4];
        t_comp p [4];
        t_comp q [4];
        logic  sat;
        t_qres res;
        int    n;
        sat  = 1'b0;
        a[0] = op.a_w;
        a[1] = op.a_i;
        a[2] = op.a_j;
        a[3] = op.a_k;
        b[0] = op.b_w;
        b[1] = op.b_i;
        b[2] = op.b_j;
        b[3] = op.b_k;
        ham_product(a, b, p, sat);
        if (op.func == FUNC_ROT) begin
            // The clipped a*b is multiplied by the conjugate; -(-2^31) stays exact.
            for (n = 0; n < 4; n++) t[n] = p[n];
            c[0] = a[0];
            c[1] = -a[1];
            c[2] = -a[2];
            c[3] = -a[3];
            ham_product(t, c, q, sat);
        end else begin
            for (n = 0; n < 4; n++) q[n] = p[n];
        end
        res.r_w = q[0];
        res.r_i = q[1];
        res.r_j = q[2];
        res.r_k = q[3];
        res.sat = sat;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    function automatic void add_op(input t_func f,
                                   input t_comp aw, input t_comp ai,
                                   input t_comp aj, input t_comp ak,
                                   input t_comp bw, input t_comp bi,
                                   input t_comp bj, input t_comp bk);
        t_qop op;
        op.func = f;
        op.a_w  = aw;
        op.a_i  = ai;
        op.a_j  = aj;
        op.a_k  = ak;
        op.b_w  = bw;
        op.b_i  = bi;
        op.b_j  = bj;
        op.b_k  = bk;
        ops_to_send.push_back(op);
    endfunction

    // Raw 32-bit patterns half the time, else the field extremes, zero, -1 or one.
    function automatic t_comp any_comp();
        case ($urandom_range(0, 9))
            0:       return COMP_MAX;
            1:       return COMP_MIN;
            2:       return '0;
            3:       return -32'sd1;
            4:       return Q_ONE;
            default: return t_comp'($urandom);
        endcase
    endfunction

    // Plain Q16.16 value within +/- span raw units.
    function automatic t_comp near_comp(input int span);
        return t_comp'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Unit quaternion from a random axis and angle.
    function automatic void unit_quat(output t_comp w, output t_comp x,
                                      output t_comp y, output t_comp z);
        real ax;
        real ay;
        real az;
        real len;
        real half;
        real s;
        ax   = real'($urandom_range(0, 2000)) - 1000.0;
        ay   = real'($urandom_range(0, 2000)) - 1000.0;
        az   = real'($urandom_range(0, 2000)) - 1000.0;
        len  = $sqrt(ax * ax + ay * ay + az * az);
        if (len == 0.0) begin
            ax  = 1.0;
            len = 1.0;
        end
        half = real'($urandom_range(0, 6283)) / 2000.0;
        s    = $sin(half) / len * 65536.0;
        w    = $rtoi($cos(half) * 65536.0);
        x    = $rtoi(ax * s);
        y    = $rtoi(ay * s);
        z    = $rtoi(az * s);
    endfunction

    function automatic void fill_ops();
        t_comp w;
        t_comp x;
        t_comp y;
        t_comp z;
        t_func f;
        int    n;
        int    kind;

        // Zero operands, identity, and the i*j = k convention.
        add_op(FUNC_MUL, 0, 0, 0, 0, 0, 0, 0, 0);
        add_op(FUNC_ROT, 0, 0, 0, 0, 0, 0, 0, 0);
        add_op(FUNC_MUL, Q_ONE, 0, 0, 0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE);
        add_op(FUNC_MUL, 0, Q_ONE, 0, 0, 0, 0, Q_ONE, 0);
        // Sum overflow at several extreme combinations.
        add_op(FUNC_MUL, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
               COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
        add_op(FUNC_MUL, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
               COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
        add_op(FUNC_MUL, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
               COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
        add_op(FUNC_MUL, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN,
               COMP_MIN, COMP_MIN, COMP_MAX, COMP_MAX);
        add_op(FUNC_MUL, 0, COMP_MIN, COMP_MIN, COMP_MIN, 0, COMP_MIN, COMP_MIN, COMP_MIN);
        // Floor rounding of a tiny negative product.
        add_op(FUNC_MUL, -32'sd1, 0, 0, 0, 32'sd1, 0, 0, 0);
        add_op(FUNC_MUL, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
               -32'sd1, -32'sd1, -32'sd1, -32'sd1);
        add_op(FUNC_MUL, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
               32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
        // Rotations: quarter turn about k, identity, non-unit a.
        add_op(FUNC_ROT, Q_COS45, 0, 0, Q_COS45, 0, Q_ONE, 0, 0);
        add_op(FUNC_ROT, Q_ONE, 0, 0, 0, COMP_MAX, COMP_MIN, 32'sd1, -32'sd1);
        add_op(FUNC_ROT, 2 * Q_ONE, 0, 0, 0, 0, 3 * Q_ONE, -Q_ONE, Q_ONE);
        // Conjugate of the most negative component.
        add_op(FUNC_ROT, 0, COMP_MIN, 0, 0, 0, 0, Q_ONE, 0);
        add_op(FUNC_ROT, 0, 0, COMP_MIN, 0, 0, COMP_MIN, COMP_MAX, 0);
        add_op(FUNC_ROT, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        // Clipped a*b feeding the second product.
        add_op(FUNC_ROT, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
               COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
        add_op(FUNC_ROT, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
               COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);

        for (n = 0; n < RANDOM_OPS; n++) begin
            f    = t_func'($urandom_range(0, 1));
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                // Well-formed: unit a for rotations, moderate values elsewhere.
                if (f == FUNC_ROT) unit_quat(w, x, y, z);
                else begin
                    w = near_comp(262144);
                    x = near_comp(262144);
                    y = near_comp(262144);
                    z = near_comp(262144);
                end
                add_op(f, w, x, y, z, near_comp(1 << 22), near_comp(1 << 22),
                       near_comp(1 << 22), near_comp(1 << 22));
            end else if (kind < 8) begin
                add_op(f, any_comp(), any_comp(), any_comp(), any_comp(),
                       any_comp(), any_comp(), any_comp(), any_comp());
            end else begin
                add_op(f, t_comp'($urandom), t_comp'($urandom), t_comp'($urandom),
                       t_comp'($urandom), t_comp'($urandom), t_comp'($urandom),
                       t_comp'($urandom), t_comp'($urandom));
            end
        end
        total_ops = ops_to_send.size();
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset.
    // ------------------------------------------------------------------

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // No idling on either side while the accepted count sits in this window.
    function automatic bit calm_stretch();
        return ops_sent >= CALM_FIRST && ops_sent < CALM_LAST;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: sample the handshake at the rising edge, drive the next
    // transaction at the falling edge. Hold the payload until accepted.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        op_taken = i_rst_n && req_if.valid && req_if.ready;
        if (op_taken) begin
            results_due.push_back(quat_result(op_on_bus));
            ops_sent++;
            if (op_on_bus.func == FUNC_ROT) rot_cnt++;
            else mul_cnt++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || op_taken) begin
            if (ops_to_send.size() != 0 &&
                (calm_stretch() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                op_on_bus      = ops_to_send.pop_front();
                req_if.valid  <= 1'b1;
                req_if.func   <= op_on_bus.func;
                req_if.a_w    <= op_on_bus.a_w;
                req_if.a_i    <= op_on_bus.a_i;
                req_if.a_j    <= op_on_bus.a_j;
                req_if.a_k    <= op_on_bus.a_k;
                req_if.b_w    <= op_on_bus.b_w;
                req_if.b_i    <= op_on_bus.b_i;
                req_if.b_j    <= op_on_bus.b_j;
                req_if.b_k    <= op_on_bus.b_k;
            end else begin
                req_if.valid  <= 1'b0;
            end
        end
    end

    // Response back-pressure: stall at random except in the calm stretch.
    always @(negedge i_clk) begin
        rsp_if.ready <= calm_stretch() || $urandom_range(0, 99) >= IDLE_PCT;
    end

    // ------------------------------------------------------------------
    // Response monitor: compare each accepted transaction with the oldest
    // prediction; flag responses that arrive with nothing outstanding.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_qres got;
        t_qres want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.r_w = rsp_if.r_w;
            got.r_i = rsp_if.r_i;
            got.r_j = rsp_if.r_j;
            got.r_k = rsp_if.r_k;
            got.sat = rsp_if.saturated;
            if (results_due.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected response w=%h i=%h j=%h k=%h sat=%b",
                         $time, got.r_w, got.r_i, got.r_j, got.r_k, got.sat);
            end else begin
                want = results_due.pop_front();
                if (got.r_w !== want.r_w || got.r_i !== want.r_i ||
                    got.r_j !== want.r_j || got.r_k !== want.r_k ||
                    got.sat !== want.sat) begin
                    err_cnt++;
                    $display("%0t: response %0d expected w=%h i=%h j=%h k=%h sat=%b",
                             $time, results_seen, want.r_w, want.r_i, want.r_j,
                             want.r_k, want.sat);
                    $display("%0t: response %0d actual   w=%h i=%h j=%h k=%h sat=%b",
                             $time, results_seen, got.r_w, got.r_i, got.r_j,
                             got.r_k, got.sat);
                end
                if (want.sat) sat_cnt++;
            end
            results_seen++;
        end
    end

    // Watchdog: end the run if no transaction moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, results_due.size());
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: load the stimulus, reset once, drain, report.
    // ------------------------------------------------------------------

    initial begin
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.func   = FUNC_MUL;
        req_if.a_w    = '0;
        req_if.a_i    = '0;
        req_if.a_j    = '0;
        req_if.a_k    = '0;
        req_if.b_w    = '0;
        req_if.b_i    = '0;
        req_if.b_j    = '0;
        req_if.b_k    = '0;
        rsp_if.ready  = 1'b0;
        op_taken      = 1'b0;
        ops_sent      = 0;
        results_seen  = 0;
        mul_cnt       = 0;
        rot_cnt       = 0;
        sat_cnt       = 0;
        err_cnt       = 0;
        quiet_cycles  = 0;
        fill_ops();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait until every transaction is accepted and every result is back.
        while (ops_sent != total_ops || results_due.size() != 0) @(negedge i_clk);
        // Then keep watching for stray responses.
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d products and %0d rotations, %0d results clipped.",
                 mul_cnt, rot_cnt, sat_cnt);
        $display("Checked %0d responses, %0d mismatches.", results_seen, err_cnt);
        if (err_cnt == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/qpr_pkg.sv
rtl/qpr_if.sv
rtl/qpr_qmul.sv
rtl/quaternion_product_and_rotation.sv
verif/testbench.sv
